/* src/rcrw_pkg.sv */
// Shared types, widths and constants for the radial cosine ring weight block.
// Used by every cell module and by the top level; depends on nothing else.
`default_nettype none
package rcrw_pkg;

    // Field and register widths.
    localparam int INDEX_BITS = 12;
    localparam int SIZE_W     = 16;
    localparam int LEN_W      = 28;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 5;
    localparam int WEIGHT_W   = 17;

    // Datapath widths that follow from the field widths.
    localparam int POS_W  = (INDEX_BITS + SIZE_W > LEN_W) ? (INDEX_BITS + SIZE_W) : LEN_W;
    localparam int ROOT_W = POS_W + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int Q_W    = 16;
    localparam int A_W    = 15;
    localparam int CF_W   = 31;
    localparam int POLY_N = 5;

    // Cosine constants in Q30.
    localparam logic [CF_W-1:0] Q30_ONE = 31'd1073741824;
    localparam logic [CF_W-1:0] COEF_K1 = 31'd1324675879;
    localparam logic [CF_W-1:0] COEF_K2 = 31'd272375560;
    localparam logic [CF_W-1:0] COEF_K3 = 31'd22401992;
    localparam logic [CF_W-1:0] COEF_K4 = 31'd987048;
    localparam logic [CF_W-1:0] COEF_K5 = 31'd27060;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_CELL_SIZE_X     = 3'd0,
        REG_CELL_SIZE_Y     = 3'd1,
        REG_ORIGIN_X        = 3'd2,
        REG_ORIGIN_Y        = 3'd3,
        REG_RING_RADIUS     = 3'd4,
        REG_RING_HALF_WIDTH = 3'd5
    } rcrw_reg_idx_t;

    // Flags that ride along with a request through the later cells.
    typedef struct packed {
        logic zero;
        logic neg;
    } rcrw_tag_t;

    // Square root cell state: radicand bits still to consume, remainder, root.
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } rcrw_sqrt_t;

    // Divider cell state: partial remainder and quotient bits so far.
    typedef struct packed {
        logic [LEN_W-1:0] rem;
        logic [Q_W-1:0]   quo;
        rcrw_tag_t        tag;
    } rcrw_div_t;

    // Polynomial cell state: Horner accumulator and squared angle.
    typedef struct packed {
        logic [CF_W-1:0] p;
        logic [CF_W-1:0] z2;
        rcrw_tag_t       tag;
    } rcrw_poly_t;

    // Coefficient used by Horner step k; the last step subtracts from one.
    function automatic logic [CF_W-1:0] poly_coef(input int k);
        logic [CF_W-1:0] c;
        c = Q30_ONE;
        case (k)
            0:       c = COEF_K4;
            1:       c = COEF_K3;
            2:       c = COEF_K2;
            3:       c = COEF_K1;
            default: c = Q30_ONE;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* src/radial_cosine_ring_weight.sv */
// Radial cosine ring weight: one request carries a grid cell index pair and returns
// a raised-cosine ring weight in Q1.16 (65536 means 1.0).
//
// Input channel: in_valid, in_stall, cell_x, cell_y. A request is taken at a rising
// edge with in_valid high and in_stall low. Output channel: out_valid, out_stall,
// weight, same rule. The user writes registers via the APB port only while idle; the block does not enforce it.
//
// The datapath is a chain of cells: four front stages (scale, offset, square, sum),
// 29 square root digit cells, a distance stage, 16 divider cells, a fold stage, a
// squaring stage and 5 Horner cells. One request is taken every cycle while in_stall
// is low; the cell chain sets that rate.
//
// Reset clears all valid bits and loads the register reset values. When out_stall
// holds a result, the next finished result moves into a skid register; only when
// that is full does the whole chain freeze and in_stall rise. in_stall is a register.
`default_nettype none
module radial_cosine_ring_weight (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [rcrw_pkg::INDEX_BITS-1:0]   cell_x,
    input  wire logic [rcrw_pkg::INDEX_BITS-1:0]   cell_y,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [rcrw_pkg::WEIGHT_W-1:0]          weight,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rcrw_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [rcrw_pkg::DATA_W-1:0]       pwdata,
    output logic [rcrw_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready
);

    localparam int POS_W  = rcrw_pkg::POS_W;
    localparam int ROOT_W = rcrw_pkg::ROOT_W;
    localparam int LEN_W  = rcrw_pkg::LEN_W;
    localparam int CF_W   = rcrw_pkg::CF_W;
    localparam int Q_W    = rcrw_pkg::Q_W;
    localparam int A_W    = rcrw_pkg::A_W;

    // Configuration registers.
    logic [rcrw_pkg::SIZE_W-1:0] cell_size_x_reg;
    logic [rcrw_pkg::SIZE_W-1:0] cell_size_y_reg;
    logic [LEN_W-1:0]            origin_x_reg;
    logic [LEN_W-1:0]            origin_y_reg;
    logic [LEN_W-1:0]            ring_radius_reg;
    logic [LEN_W-1:0]            ring_half_width_reg;

    rcrw_pkg::rcrw_reg_idx_t     reg_idx;
    logic                        cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = rcrw_pkg::rcrw_reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_x_reg     <= 16'd4096;
            cell_size_y_reg     <= 16'd4096;
            origin_x_reg        <= '0;
            origin_y_reg        <= '0;
            ring_radius_reg     <= '0;
            ring_half_width_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                rcrw_pkg::REG_CELL_SIZE_X:     cell_size_x_reg     <= pwdata[15:0];
                rcrw_pkg::REG_CELL_SIZE_Y:     cell_size_y_reg     <= pwdata[15:0];
                rcrw_pkg::REG_ORIGIN_X:        origin_x_reg        <= pwdata[LEN_W-1:0];
                rcrw_pkg::REG_ORIGIN_Y:        origin_y_reg        <= pwdata[LEN_W-1:0];
                rcrw_pkg::REG_RING_RADIUS:     ring_radius_reg     <= pwdata[LEN_W-1:0];
                rcrw_pkg::REG_RING_HALF_WIDTH: ring_half_width_reg <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            rcrw_pkg::REG_CELL_SIZE_X:     prdata = 32'(cell_size_x_reg);
            rcrw_pkg::REG_CELL_SIZE_Y:     prdata = 32'(cell_size_y_reg);
            rcrw_pkg::REG_ORIGIN_X:        prdata = 32'(origin_x_reg);
            rcrw_pkg::REG_ORIGIN_Y:        prdata = 32'(origin_y_reg);
            rcrw_pkg::REG_RING_RADIUS:     prdata = 32'(ring_radius_reg);
            rcrw_pkg::REG_RING_HALF_WIDTH: prdata = 32'(ring_half_width_reg);
            default:                       prdata = '0;
        endcase
    end

    // The whole chain advances unless the skid register is occupied.
    logic skid_valid_reg;
    logic en;
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // Front stages: scale, offset, square, sum.
    logic                 valid_a_reg, valid_b_reg, valid_c_reg, valid_d_reg;
    logic [POS_W-1:0]     px_reg, py_reg, px_next, py_next;
    logic [POS_W-1:0]     mx_reg, my_reg, mx_next, my_next;
    logic [2*POS_W-1:0]   sqx_reg, sqy_reg, sqx_next, sqy_next;
    logic [rcrw_pkg::RAD_W-1:0] sum_reg, sum_next;
    logic [POS_W-1:0]     ox, oy;

    always_comb
    begin
        ox       = POS_W'(origin_x_reg);
        oy       = POS_W'(origin_y_reg);
        px_next  = POS_W'(cell_x) * POS_W'(cell_size_x_reg);
        py_next  = POS_W'(cell_y) * POS_W'(cell_size_y_reg);
        mx_next  = (px_reg >= ox) ? (px_reg - ox) : (ox - px_reg);
        my_next  = (py_reg >= oy) ? (py_reg - oy) : (oy - py_reg);
        sqx_next = mx_reg * mx_reg;
        sqy_next = my_reg * my_reg;
        sum_next = rcrw_pkg::RAD_W'(sqx_reg) + rcrw_pkg::RAD_W'(sqy_reg);
    end

    // Distance, fold and squaring stages.
    logic                      valid_e_reg, valid_f_reg, valid_g_reg;
    logic [ROOT_W-1:0]         ad_next;
    logic                      zero_next;
    rcrw_pkg::rcrw_div_t       div_in_reg, div_in_next;
    logic [A_W-1:0]            ang_reg, ang_next;
    logic [2*A_W-1:0]          ang_sq;
    rcrw_pkg::rcrw_tag_t       tag_f_reg, tag_f_next;
    rcrw_pkg::rcrw_poly_t      poly_in_reg, poly_in_next;
    logic [Q_W:0]              s17, a17;

    // Square root and divider chain links.
    logic                 sqrt_valid [0:ROOT_W];
    rcrw_pkg::rcrw_sqrt_t sqrt_st    [0:ROOT_W];
    logic                 div_valid  [0:Q_W];
    rcrw_pkg::rcrw_div_t  div_st     [0:Q_W];

    // Valid bits of the stages held in this module.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            valid_e_reg <= 1'b0;
            valid_f_reg <= 1'b0;
            valid_g_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
            valid_e_reg <= sqrt_valid[ROOT_W];
            valid_f_reg <= div_valid[Q_W];
            valid_g_reg <= valid_f_reg;
        end
    end

    // Square root chain.
    assign sqrt_valid[0]   = valid_d_reg;
    assign sqrt_st[0].rad  = sum_reg;
    assign sqrt_st[0].rem  = '0;
    assign sqrt_st[0].root = '0;

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        rcrw_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sqrt_valid[i]),
            .st_in     (sqrt_st[i]),
            .valid_out (sqrt_valid[i+1]),
            .st_out    (sqrt_st[i+1])
        );
    end

    // Distance from the ring and the zero test.
    always_comb
    begin
        ad_next = (sqrt_st[ROOT_W].root >= ROOT_W'(ring_radius_reg))
                ? (sqrt_st[ROOT_W].root - ROOT_W'(ring_radius_reg))
                : (ROOT_W'(ring_radius_reg) - sqrt_st[ROOT_W].root);
        zero_next = (ad_next >= ROOT_W'(ring_half_width_reg));
        div_in_next.rem      = ad_next[LEN_W-1:0];
        div_in_next.quo      = '0;
        div_in_next.tag.zero = zero_next;
        div_in_next.tag.neg  = 1'b0;
    end

    // Divider chain for the turn fraction.
    assign div_valid[0] = valid_e_reg;
    assign div_st[0]    = div_in_reg;

    for (genvar i = 0; i < Q_W; i++)
    begin : g_div
        rcrw_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .divisor   (ring_half_width_reg),
            .valid_in  (div_valid[i]),
            .st_in     (div_st[i]),
            .valid_out (div_valid[i+1]),
            .st_out    (div_st[i+1])
        );
    end

    // Fold the turn fraction into the first quarter wave.
    always_comb
    begin
        s17 = (div_st[Q_W].quo <= 16'd32768) ? {1'b0, div_st[Q_W].quo}
                                             : (17'd65536 - {1'b0, div_st[Q_W].quo});
        tag_f_next.zero = div_st[Q_W].tag.zero;
        tag_f_next.neg  = (s17 > 17'd16384);
        a17      = tag_f_next.neg ? (17'd32768 - s17) : s17;
        ang_next = a17[A_W-1:0];
    end

    // Square the angle into Q30 and seed the Horner chain.
    always_comb
    begin
        ang_sq           = (2*A_W)'(ang_reg) * (2*A_W)'(ang_reg);
        poly_in_next.z2  = CF_W'({ang_sq, 2'b00});
        poly_in_next.p   = rcrw_pkg::COEF_K5;
        poly_in_next.tag = tag_f_reg;
    end

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg      <= px_next;
            py_reg      <= py_next;
            mx_reg      <= mx_next;
            my_reg      <= my_next;
            sqx_reg     <= sqx_next;
            sqy_reg     <= sqy_next;
            sum_reg     <= sum_next;
            div_in_reg  <= div_in_next;
            ang_reg     <= ang_next;
            tag_f_reg   <= tag_f_next;
            poly_in_reg <= poly_in_next;
        end
    end

    // Horner chain for the cosine.
    logic                 poly_valid [0:rcrw_pkg::POLY_N];
    rcrw_pkg::rcrw_poly_t poly_st    [0:rcrw_pkg::POLY_N];

    assign poly_valid[0] = valid_g_reg;
    assign poly_st[0]    = poly_in_reg;

    for (genvar i = 0; i < rcrw_pkg::POLY_N; i++)
    begin : g_poly
        rcrw_poly_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .coef      (rcrw_pkg::poly_coef(i)),
            .valid_in  (poly_valid[i]),
            .st_in     (poly_st[i]),
            .valid_out (poly_valid[i+1]),
            .st_out    (poly_st[i+1])
        );
    end

    // Raised cosine, rounded to Q1.16, saturated at one and zero when the zero tag is set.
    logic [32:0]                   wsum;
    logic [rcrw_pkg::WEIGHT_W-1:0] wraw;
    logic [rcrw_pkg::WEIGHT_W-1:0] wfinal;
    logic                          pv;
    rcrw_pkg::rcrw_poly_t          pst;

    assign pv  = poly_valid[rcrw_pkg::POLY_N];
    assign pst = poly_st[rcrw_pkg::POLY_N];

    always_comb
    begin
        if (pst.tag.neg)
        begin
            wsum = 33'h0_4000_4000 - 33'(pst.p);
        end
        else
        begin
            wsum = 33'h0_4000_4000 + 33'(pst.p);
        end
        wraw = wsum[31:15];
        priority if (pst.tag.zero)
        begin
            wfinal = '0;
        end
        else if (wraw > 17'd65536)
        begin
            wfinal = 17'd65536;
        end
        else
        begin
            wfinal = wraw;
        end
    end

    // Output register with a skid register behind it.
    logic                          out_valid_reg;
    logic [rcrw_pkg::WEIGHT_W-1:0] out_weight_reg;
    logic [rcrw_pkg::WEIGHT_W-1:0] skid_weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pv;
            end
        end
        else if (!skid_valid_reg && pv)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            out_weight_reg <= skid_valid_reg ? skid_weight_reg : wfinal;
        end
        else if (!skid_valid_reg)
        begin
            skid_weight_reg <= wfinal;
        end
    end

    assign out_valid = out_valid_reg;
    assign weight    = out_weight_reg;

    // The skid register is only filled behind a held result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output is empty");

    // A free output drains the skid register at once.
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> !skid_valid_reg)
        else $error("skid register not drained when the output was free");

    // A delivered weight never exceeds one.
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_weight_reg <= 17'd65536))
        else $error("weight above 1.0");

endmodule
`default_nettype wire

/* src/rcrw_sqrt_cell.sv */
// One digit cell of the pipelined integer square root: two radicand bits per cell.
// Depends on rcrw_pkg for the state type and widths.
`default_nettype none
module rcrw_sqrt_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               valid_in,
    input  wire rcrw_pkg::rcrw_sqrt_t st_in,
    output logic                    valid_out,
    output rcrw_pkg::rcrw_sqrt_t    st_out
);

    logic                        valid_reg;
    rcrw_pkg::rcrw_sqrt_t        st_reg;
    rcrw_pkg::rcrw_sqrt_t        st_next;
    logic [rcrw_pkg::REM_W-1:0]  rem_sh;
    logic [rcrw_pkg::REM_W-1:0]  trial;

    // Bring down two radicand bits and try to set the next root bit.
    always_comb
    begin
        rem_sh = {st_in.rem[rcrw_pkg::REM_W-3:0], st_in.rad[rcrw_pkg::RAD_W-1 -: 2]};
        trial  = rcrw_pkg::REM_W'({st_in.root, 2'b01});
        st_next.rad = {st_in.rad[rcrw_pkg::RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            st_next.rem  = rem_sh - trial;
            st_next.root = {st_in.root[rcrw_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            st_next.rem  = rem_sh;
            st_next.root = {st_in.root[rcrw_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    // Valid bit is control state; the payload needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign valid_out = valid_reg;
    assign st_out    = st_reg;

endmodule
`default_nettype wire

/* src/rcrw_div_cell.sv */
// One quotient bit cell of the pipelined restoring divider for the turn fraction.
// Depends on rcrw_pkg for the state type and widths.
`default_nettype none
module rcrw_div_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic [rcrw_pkg::LEN_W-1:0]  divisor,
    input  wire logic                        valid_in,
    input  wire rcrw_pkg::rcrw_div_t         st_in,
    output logic                             valid_out,
    output rcrw_pkg::rcrw_div_t              st_out
);

    logic                        valid_reg;
    rcrw_pkg::rcrw_div_t         st_reg;
    rcrw_pkg::rcrw_div_t         st_next;
    logic [rcrw_pkg::LEN_W:0]    rem2;
    logic [rcrw_pkg::LEN_W:0]    dvs;
    logic                        ge;

    // Double the remainder and subtract the divisor when it fits.
    always_comb
    begin
        rem2 = {st_in.rem, 1'b0};
        dvs  = {1'b0, divisor};
        ge   = (rem2 >= dvs);
        st_next.tag = st_in.tag;
        st_next.quo = {st_in.quo[rcrw_pkg::Q_W-2:0], ge};
        if (ge)
        begin
            st_next.rem = rcrw_pkg::LEN_W'(rem2 - dvs);
        end
        else
        begin
            st_next.rem = rem2[rcrw_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign valid_out = valid_reg;
    assign st_out    = st_reg;

endmodule
`default_nettype wire

/* src/rcrw_poly_cell.sv */
// One Horner step of the quarter-wave cosine polynomial: p = coef - p*z2 in Q30.
// Depends on rcrw_pkg for the state type and widths.
`default_nettype none
module rcrw_poly_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic [rcrw_pkg::CF_W-1:0]  coef,
    input  wire logic                       valid_in,
    input  wire rcrw_pkg::rcrw_poly_t       st_in,
    output logic                            valid_out,
    output rcrw_pkg::rcrw_poly_t            st_out
);

    logic                          valid_reg;
    rcrw_pkg::rcrw_poly_t          st_reg;
    rcrw_pkg::rcrw_poly_t          st_next;
    logic [2*rcrw_pkg::CF_W-1:0]   prod;
    logic [rcrw_pkg::CF_W:0]       prod_q30;

    // Multiply, drop to Q30 and subtract from the coefficient, clamped at zero.
    always_comb
    begin
        prod     = st_in.p * st_in.z2;
        prod_q30 = prod[2*rcrw_pkg::CF_W-1:30];
        st_next.z2  = st_in.z2;
        st_next.tag = st_in.tag;
        if ({1'b0, coef} >= prod_q30)
        begin
            st_next.p = coef - prod_q30[rcrw_pkg::CF_W-1:0];
        end
        else
        begin
            st_next.p = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign valid_out = valid_reg;
    assign st_out    = st_reg;

endmodule
`default_nettype wire
